[src/tsvf_pkg.sv]
package tsvf_pkg;

	// Default widths of the sample and coefficient formats
	localparam int SAMPLE_WIDTH_DEF = 24;
	localparam int COEF_WIDTH_DEF   = 20;

	// Integrator states are signed 32-bit with the sample's fraction bits
	localparam int STATE_WIDTH = 32;

	// Integer bits of a Q4.x coefficient
	localparam int COEF_INT_BITS = 4;

	// Coefficients packed per register: state one, state two, output
	localparam int NUM_LANES = 3;
	localparam int LANE_S1   = 0;
	localparam int LANE_S2   = 1;
	localparam int LANE_OUT  = 2;

	// Configuration register indexes
	localparam int CFG_INDEX_WIDTH = 2;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_COEFF_INPUT     = 2'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_COEFF_STATE_ONE = 2'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_COEFF_STATE_TWO = 2'd2;

endpackage

[src/trapezoidal_svf_core.sv]
// Trapezoidal state-variable filter core, mono, fixed point.
//
// Input stream s_axis: tdata carries the signed Q1.(SAMPLE_WIDTH-1) sample,
// tlast marks the last sample of a block. Output stream m_axis: tdata
// carries the filtered sample (saturated), tlast is the copied mark.
// Configuration: cfg_we/cfg_index/cfg_data write the three packed
// coefficient registers (input weights, state one weights, state two
// weights), each holding three Q4.x coefficients for state one, state two
// and output. Write them only while no sample is in flight.
//
// Throughput is one sample per cycle while the receiver does not stall. A
// sample is captured in the input register at its transaction; the nine
// multiplies, the rounding, the sums and the saturation run combinationally
// from there into the output register and the two integrator registers,
// which take the result when the output register is free or drained. The
// integrator feedback loop sets the rate.
//
// Reset clears the coefficients, both integrators and all valid flags.
// When the receiver stalls, the result holds in the output register and one
// more sample is taken into the input register; then s_axis_tready drops.
module trapezoidal_svf_core import tsvf_pkg::*; #(
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
	parameter int COEF_WIDTH   = COEF_WIDTH_DEF,
	localparam int TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8,
	localparam int REG_W   = NUM_LANES * COEF_WIDTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	input  logic [TDATA_W-1:0]         s_axis_tdata,  // [SAMPLE_WIDTH-1:0] sample
	input  logic                       s_axis_tlast,
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	output logic [TDATA_W-1:0]         m_axis_tdata,  // [SAMPLE_WIDTH-1:0] filtered
	output logic                       m_axis_tlast,
	input  logic                       cfg_we,
	input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [REG_W-1:0]           cfg_data
);

	localparam int SUM_W  = STATE_WIDTH + COEF_INT_BITS + 2;
	localparam int DIFF_W = SUM_W + 1;

	localparam logic signed [STATE_WIDTH-1:0] STATE_MAX = {1'b0, {(STATE_WIDTH-1){1'b1}}};
	localparam logic signed [STATE_WIDTH-1:0] STATE_MIN = {1'b1, {(STATE_WIDTH-1){1'b0}}};
	localparam logic signed [SAMPLE_WIDTH-1:0] OUT_MAX  = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
	localparam logic signed [SAMPLE_WIDTH-1:0] OUT_MIN  = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

	logic [REG_W-1:0] coeff_input, coeff_state_one, coeff_state_two;

	logic                           valid_s1;
	logic signed [SAMPLE_WIDTH-1:0] sample_s1;
	logic                           last_s1;

	logic                           out_valid_q;
	logic        [SAMPLE_WIDTH-1:0] out_data_q;
	logic                           out_last_q;

	logic signed [STATE_WIDTH-1:0] integ1_q, integ2_q;

	logic                          advance;
	logic signed [STATE_WIDTH-1:0] v_ext;
	logic signed [SUM_W-1:0]       t_lane [NUM_LANES];
	logic signed [DIFF_W-1:0]      diff1, diff2;
	logic signed [STATE_WIDTH-1:0] next1, next2;
	logic signed [SAMPLE_WIDTH-1:0] out_sat;

	tsvf_coef_regs #(.COEF_WIDTH(COEF_WIDTH)) u_regs (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.coeff_input     (coeff_input),
		.coeff_state_one (coeff_state_one),
		.coeff_state_two (coeff_state_two)
	);

	// Move the held sample on when the output register is free or drained
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			sample_s1 <= s_axis_tdata[SAMPLE_WIDTH-1:0];
			last_s1   <= s_axis_tlast;
		end
	end

	assign v_ext = STATE_WIDTH'(sample_s1);

	// One multiply-accumulate lane per row of the coefficient matrix
	for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
		tsvf_mac #(.COEF_WIDTH(COEF_WIDTH)) u_mac (
			.coef_v  (coeff_input[k*COEF_WIDTH +: COEF_WIDTH]),
			.coef_s1 (coeff_state_one[k*COEF_WIDTH +: COEF_WIDTH]),
			.coef_s2 (coeff_state_two[k*COEF_WIDTH +: COEF_WIDTH]),
			.v       (v_ext),
			.s1      (integ1_q),
			.s2      (integ2_q),
			.t       (t_lane[k])
		);
	end

	// New integrator values, saturated to the state range
	assign diff1 = DIFF_W'(t_lane[LANE_S1]) - DIFF_W'(integ1_q);
	assign diff2 = DIFF_W'(t_lane[LANE_S2]) - DIFF_W'(integ2_q);

	always_comb begin
		if (diff1[DIFF_W-1:STATE_WIDTH-1] == {(DIFF_W-STATE_WIDTH+1){diff1[DIFF_W-1]}}) begin
			next1 = diff1[STATE_WIDTH-1:0];
		end else begin
			next1 = diff1[DIFF_W-1] ? STATE_MIN : STATE_MAX;
		end
		if (diff2[DIFF_W-1:STATE_WIDTH-1] == {(DIFF_W-STATE_WIDTH+1){diff2[DIFF_W-1]}}) begin
			next2 = diff2[STATE_WIDTH-1:0];
		end else begin
			next2 = diff2[DIFF_W-1] ? STATE_MIN : STATE_MAX;
		end
	end

	// Output sample, saturated to the sample range
	always_comb begin
		if (t_lane[LANE_OUT][SUM_W-1:SAMPLE_WIDTH-1] ==
		    {(SUM_W-SAMPLE_WIDTH+1){t_lane[LANE_OUT][SUM_W-1]}}) begin
			out_sat = t_lane[LANE_OUT][SAMPLE_WIDTH-1:0];
		end else begin
			out_sat = t_lane[LANE_OUT][SUM_W-1] ? OUT_MIN : OUT_MAX;
		end
	end

	// Integrator state, updated once per processed sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ1_q <= '0;
			integ2_q <= '0;
		end else if (advance) begin
			integ1_q <= next1;
			integ2_q <= next2;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || m_axis_tready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= out_sat;
			out_last_q <= last_s1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = TDATA_W'(out_data_q);
	assign m_axis_tlast  = out_last_q;

endmodule

[src/tsvf_coef_regs.sv]
module tsvf_coef_regs import tsvf_pkg::*; #(
	parameter int COEF_WIDTH = COEF_WIDTH_DEF,
	localparam int REG_W = NUM_LANES * COEF_WIDTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [REG_W-1:0]           cfg_data,
	output logic [REG_W-1:0]           coeff_input,
	output logic [REG_W-1:0]           coeff_state_one,
	output logic [REG_W-1:0]           coeff_state_two
);

	logic [REG_W-1:0] coeff_input_q;
	logic [REG_W-1:0] coeff_state_one_q;
	logic [REG_W-1:0] coeff_state_two_q;

	// Take a write at the addressed register, drop unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coeff_input_q     <= '0;
			coeff_state_one_q <= '0;
			coeff_state_two_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_COEFF_INPUT:     coeff_input_q     <= cfg_data;
				REG_COEFF_STATE_ONE: coeff_state_one_q <= cfg_data;
				REG_COEFF_STATE_TWO: coeff_state_two_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign coeff_input     = coeff_input_q;
	assign coeff_state_one = coeff_state_one_q;
	assign coeff_state_two = coeff_state_two_q;

endmodule

[src/tsvf_mac.sv]
module tsvf_mac import tsvf_pkg::*; #(
	parameter int COEF_WIDTH = COEF_WIDTH_DEF,
	localparam int PROD_W = COEF_WIDTH + STATE_WIDTH,
	localparam int FRAC   = COEF_WIDTH - COEF_INT_BITS,
	localparam int RND_W  = PROD_W - FRAC,
	localparam int SUM_W  = RND_W + 2
) (
	input  logic signed [COEF_WIDTH-1:0]  coef_v,
	input  logic signed [COEF_WIDTH-1:0]  coef_s1,
	input  logic signed [COEF_WIDTH-1:0]  coef_s2,
	input  logic signed [STATE_WIDTH-1:0] v,
	input  logic signed [STATE_WIDTH-1:0] s1,
	input  logic signed [STATE_WIDTH-1:0] s2,
	output logic signed [SUM_W-1:0]       t
);

	// Half an output LSB, added before the floor shift
	localparam logic signed [PROD_W-1:0] HALF =
		{{(PROD_W-FRAC){1'b0}}, 1'b1, {(FRAC-1){1'b0}}};

	logic signed [PROD_W-1:0] prod_v, prod_s1, prod_s2;
	logic signed [PROD_W-1:0] rnd_v, rnd_s1, rnd_s2;
	logic signed [RND_W-1:0]  trim_v, trim_s1, trim_s2;

	// Full products, all operands signed
	assign prod_v  = coef_v  * v;
	assign prod_s1 = coef_s1 * s1;
	assign prod_s2 = coef_s2 * s2;

	// Round half up to the sample's fraction bits
	assign rnd_v  = prod_v  + HALF;
	assign rnd_s1 = prod_s1 + HALF;
	assign rnd_s2 = prod_s2 + HALF;
	assign trim_v  = rnd_v[PROD_W-1:FRAC];
	assign trim_s1 = rnd_s1[PROD_W-1:FRAC];
	assign trim_s2 = rnd_s2[PROD_W-1:FRAC];

	// Exact sum of the three rounded terms
	assign t = SUM_W'(trim_v) + SUM_W'(trim_s1) + SUM_W'(trim_s2);

endmodule

[src/tsvf_checker.sv]
module tsvf_checker import tsvf_pkg::*; #(
	parameter int TDATA_W = 24
) (
	input logic               clk,
	input logic               arst_n,
	input logic               s_axis_tvalid,
	input logic               s_axis_tready,
	input logic               m_axis_tvalid,
	input logic               m_axis_tready,
	input logic [TDATA_W-1:0] m_axis_tdata,
	input logic               m_axis_tlast
);

	// Hold a stalled result unchanged
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("stalled output transaction changed");

	// A draining receiver never blocks the input side
	a_no_block: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tready |-> s_axis_tready)
		else $error("input stalled while output drains");

	// An accepted sample reaches the output when not stalled
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) ##1 m_axis_tready |=> m_axis_tvalid)
		else $error("accepted sample did not reach the output");

endmodule

bind trapezoidal_svf_core tsvf_checker #(.TDATA_W(TDATA_W)) u_tsvf_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);

[test/svf_output_checker.sv]
module svf_output_checker import tsvf_pkg::*; (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      s_axis_tvalid,
	input  logic                                      s_axis_tready,
	input  logic [((SAMPLE_WIDTH_DEF+7)/8)*8-1:0]     s_axis_tdata,  // sample
	input  logic                                      s_axis_tlast,
	input  logic                                      m_axis_tvalid,
	input  logic                                      m_axis_tready,
	input  logic [((SAMPLE_WIDTH_DEF+7)/8)*8-1:0]     m_axis_tdata,  // filtered
	input  logic                                      m_axis_tlast,
	input  logic                                      cfg_we,
	input  logic [CFG_INDEX_WIDTH-1:0]                cfg_index,
	input  logic [NUM_LANES*COEF_WIDTH_DEF-1:0]       cfg_data,
	output int                                        mismatches,
	output int                                        in_flight
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF;
	localparam int COEF_WIDTH   = COEF_WIDTH_DEF;
	localparam int REG_W        = NUM_LANES * COEF_WIDTH;
	localparam int FRAC_BITS    = COEF_WIDTH - COEF_INT_BITS;
	localparam longint ROUND_HALF = 64'sd1 <<< (FRAC_BITS - 1);
	localparam longint STATE_MAX  = (64'sd1 <<< (STATE_WIDTH - 1)) - 1;
	localparam longint STATE_MIN  = -STATE_MAX - 1;
	localparam longint OUT_MAX    = (64'sd1 <<< (SAMPLE_WIDTH - 1)) - 1;
	localparam longint OUT_MIN    = -OUT_MAX - 1;

	typedef struct packed {
		logic [SAMPLE_WIDTH-1:0] filtered;
		logic                    block_end;
	} svf_result_t;

	// Shadow of the coefficient registers and the two integrators
	logic [REG_W-1:0]              w_input;
	logic [REG_W-1:0]              w_state_one;
	logic [REG_W-1:0]              w_state_two;
	logic signed [STATE_WIDTH-1:0] integ_one;
	logic signed [STATE_WIDTH-1:0] integ_two;

	svf_result_t expected_filtered[$];
	int          mismatch_count = 0;

	// One coefficient times an operand, rounded half up to the operand's fraction bits
	function automatic longint rounded_mul(logic [REG_W-1:0] weights, int lane, longint operand);
		logic signed [COEF_WIDTH-1:0] coef;
		longint                       prod;
		coef = weights[lane*COEF_WIDTH +: COEF_WIDTH];
		prod = longint'(coef) * operand;
		return (prod + ROUND_HALF) >>> FRAC_BITS;
	endfunction

	function automatic longint saturate(longint x, longint lo, longint hi);
		if (x < lo) begin
			return lo;
		end
		if (x > hi) begin
			return hi;
		end
		return x;
	endfunction

	// Advance the integrators by one sample and return the filtered output
	function automatic svf_result_t filter_sample(logic signed [SAMPLE_WIDTH-1:0] smp, logic mark);
		longint      v;
		longint      s1;
		longint      s2;
		longint      acc [NUM_LANES];
		longint      clipped;
		svf_result_t res;
		v  = smp;
		s1 = integ_one;
		s2 = integ_two;
		for (int k = 0; k < NUM_LANES; k++) begin
			acc[k] = rounded_mul(w_input, k, v) + rounded_mul(w_state_one, k, s1)
			       + rounded_mul(w_state_two, k, s2);
		end
		clipped   = saturate(acc[LANE_S1] - s1, STATE_MIN, STATE_MAX);
		integ_one = clipped[STATE_WIDTH-1:0];
		clipped   = saturate(acc[LANE_S2] - s2, STATE_MIN, STATE_MAX);
		integ_two = clipped[STATE_WIDTH-1:0];
		clipped   = saturate(acc[LANE_OUT], OUT_MIN, OUT_MAX);
		res.filtered  = clipped[SAMPLE_WIDTH-1:0];
		res.block_end = mark;
		return res;
	endfunction

	task automatic report_mismatch(string field, longint got, longint want);
		mismatch_count++;
		$display("%0t ns: mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
	endtask

	// Track config writes, predict on each input transaction, check each output one
	always @(posedge clk or negedge arst_n) begin : monitor
		svf_result_t want;
		if (!arst_n) begin
			w_input     = '0;
			w_state_one = '0;
			w_state_two = '0;
			integ_one   = '0;
			integ_two   = '0;
			expected_filtered.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_COEFF_INPUT:     w_input     = cfg_data;
					REG_COEFF_STATE_ONE: w_state_one = cfg_data;
					REG_COEFF_STATE_TWO: w_state_two = cfg_data;
					default: ;
				endcase
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_filtered.size() == 0) begin
					report_mismatch("unexpected result, filtered",
						longint'(signed'(m_axis_tdata[SAMPLE_WIDTH-1:0])), 0);
				end else begin
					want = expected_filtered.pop_front();
					if (m_axis_tdata[SAMPLE_WIDTH-1:0] !== want.filtered) begin
						report_mismatch("filtered",
							longint'(signed'(m_axis_tdata[SAMPLE_WIDTH-1:0])),
							longint'(signed'(want.filtered)));
					end
					if (m_axis_tlast !== want.block_end) begin
						report_mismatch("block end mark", longint'(m_axis_tlast),
							longint'(want.block_end));
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				expected_filtered.push_back(filter_sample(s_axis_tdata[SAMPLE_WIDTH-1:0],
					s_axis_tlast));
			end
		end
		in_flight  <= expected_filtered.size();
		mismatches <= mismatch_count;
	end

endmodule

[test/tb_trapezoidal_svf_core.sv]
module tb_trapezoidal_svf_core;
	timeunit 1ns;
	timeprecision 1ps;

	import tsvf_pkg::*;

	localparam int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF;
	localparam int COEF_WIDTH   = COEF_WIDTH_DEF;
	localparam int TDATA_W      = ((SAMPLE_WIDTH + 7) / 8) * 8;
	localparam int REG_W        = NUM_LANES * COEF_WIDTH;

	// Index past the last register: the block must ignore writes to it
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNUSED = 2'd3;

	localparam logic [SAMPLE_WIDTH-1:0] SMP_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
	localparam logic [SAMPLE_WIDTH-1:0] SMP_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
	localparam int COEF_ONE = 1 << (COEF_WIDTH - COEF_INT_BITS);
	localparam int COEF_MAX = (1 << (COEF_WIDTH - 1)) - 1;
	localparam int COEF_MIN = -(1 << (COEF_WIDTH - 1));

	localparam int LATENCY        = 2;
	localparam int ITEMS_PER_MODE = 500;
	localparam int WATCHDOG_LIMIT = 5000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_axis_tvalid = 1'b0;
	logic               s_axis_tready;
	logic [TDATA_W-1:0] s_axis_tdata = '0;  // [SAMPLE_WIDTH-1:0] sample
	logic               s_axis_tlast = 1'b0;
	logic               m_axis_tvalid;
	logic               m_axis_tready = 1'b0;
	logic [TDATA_W-1:0] m_axis_tdata;       // [SAMPLE_WIDTH-1:0] filtered
	logic               m_axis_tlast;
	logic               cfg_we = 1'b0;
	logic [CFG_INDEX_WIDTH-1:0] cfg_index = REG_COEFF_INPUT;
	logic [REG_W-1:0]   cfg_data = '0;

	int mismatch_total;
	int samples_in_flight;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int block_left = 0;
	logic [SAMPLE_WIDTH-1:0] last_sample = '0;

	trapezoidal_svf_core uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	svf_output_checker chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.mismatches    (mismatch_total),
		.in_flight     (samples_in_flight)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Stall the output side at random
	initial begin
		forever begin
			@(posedge clk);
			m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// End the run when no transaction moves for too long
	initial begin
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
		end
		$display("** trapezoidal_svf_core: FAILED **");
		$finish;
	end

	function automatic logic [REG_W-1:0] pack_lanes(int c_s1, int c_s2, int c_out);
		return {c_out[COEF_WIDTH-1:0], c_s2[COEF_WIDTH-1:0], c_s1[COEF_WIDTH-1:0]};
	endfunction

	function automatic int to_q16(real x);
		return $rtoi(x * real'(COEF_ONE));
	endfunction

	function automatic int extreme_coef();
		case ($urandom_range(0, 3))
			0:       return COEF_MAX;
			1:       return COEF_MIN;
			2:       return 0;
			default: return COEF_ONE;
		endcase
	endfunction

	// Random input: mostly full range, some small, some at the rails, some held
	function automatic logic [SAMPLE_WIDTH-1:0] pick_sample();
		logic [31:0] r;
		int          small_val;
		r = $urandom;
		small_val = int'($urandom_range(0, 8191)) - 4096;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: last_sample = r[SAMPLE_WIDTH-1:0];
			5, 6:          last_sample = small_val[SAMPLE_WIDTH-1:0];
			7:             last_sample = r[31] ? SMP_MAX : SMP_MIN;
			default: ;
		endcase
		return last_sample;
	endfunction

	// Pick a coefficient set: mostly a stable filter, sometimes noise or rail values
	task automatic pick_weights(output logic [REG_W-1:0] w_in, output logic [REG_W-1:0] w_s1,
			output logic [REG_W-1:0] w_s2);
		real         g;
		real         damp;
		real         a1;
		real         a2;
		real         a3;
		logic [63:0] r0;
		logic [63:0] r1;
		logic [63:0] r2;
		g    = 0.005 + $urandom_range(0, 4000) / 1000.0;
		damp = 0.05 + $urandom_range(0, 1950) / 1000.0;
		a1   = 1.0 / (1.0 + g * (g + damp));
		a2   = g * a1;
		a3   = g * a2;
		r0   = {$urandom, $urandom};
		r1   = {$urandom, $urandom};
		r2   = {$urandom, $urandom};
		case ($urandom_range(0, 9))
			0, 1: begin
				// low-pass output
				w_in = pack_lanes(to_q16(2.0 * a2), to_q16(2.0 * a3), to_q16(a3));
				w_s1 = pack_lanes(to_q16(2.0 * a1), to_q16(2.0 * a2), to_q16(a2));
				w_s2 = pack_lanes(to_q16(-2.0 * a2), to_q16(2.0 - 2.0 * a3), to_q16(1.0 - a3));
			end
			2, 3: begin
				// band-pass output
				w_in = pack_lanes(to_q16(2.0 * a2), to_q16(2.0 * a3), to_q16(a2));
				w_s1 = pack_lanes(to_q16(2.0 * a1), to_q16(2.0 * a2), to_q16(a1));
				w_s2 = pack_lanes(to_q16(-2.0 * a2), to_q16(2.0 - 2.0 * a3), to_q16(-a2));
			end
			4, 5: begin
				// high-pass output
				w_in = pack_lanes(to_q16(2.0 * a2), to_q16(2.0 * a3),
					to_q16(1.0 - damp * a2 - a3));
				w_s1 = pack_lanes(to_q16(2.0 * a1), to_q16(2.0 * a2), to_q16(-damp * a1 - a2));
				w_s2 = pack_lanes(to_q16(-2.0 * a2), to_q16(2.0 - 2.0 * a3),
					to_q16(damp * a2 - 1.0 + a3));
			end
			6, 7: begin
				w_in = r0[REG_W-1:0];
				w_s1 = r1[REG_W-1:0];
				w_s2 = r2[REG_W-1:0];
			end
			default: begin
				w_in = pack_lanes(extreme_coef(), extreme_coef(), extreme_coef());
				w_s1 = pack_lanes(extreme_coef(), extreme_coef(), extreme_coef());
				w_s2 = pack_lanes(extreme_coef(), extreme_coef(), extreme_coef());
			end
		endcase
	endtask

	// Write all three registers back to back, optionally followed by a stray index
	task automatic load_weights(input logic [REG_W-1:0] w_in, input logic [REG_W-1:0] w_s1,
			input logic [REG_W-1:0] w_s2, input bit stray);
		logic [63:0] junk;
		junk = {$urandom, $urandom};
		cfg_we    <= 1'b1;
		cfg_index <= REG_COEFF_INPUT;
		cfg_data  <= w_in;
		@(posedge clk);
		cfg_index <= REG_COEFF_STATE_ONE;
		cfg_data  <= w_s1;
		@(posedge clk);
		cfg_index <= REG_COEFF_STATE_TWO;
		cfg_data  <= w_s2;
		@(posedge clk);
		if (stray) begin
			cfg_index <= REG_UNUSED;
			cfg_data  <= junk[REG_W-1:0];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	// Offer one sample and hold it until the transaction completes
	task automatic send_sample(input logic [SAMPLE_WIDTH-1:0] smp, input logic mark);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= TDATA_W'(smp);
		s_axis_tlast  <= mark;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// Stop sending and wait until every result is back and the pipeline is empty
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (samples_in_flight != 0) @(posedge clk);
		repeat (LATENCY + 1) @(posedge clk);
	endtask

	initial begin
		logic [REG_W-1:0] w_in;
		logic [REG_W-1:0] w_s1;
		logic [REG_W-1:0] w_s2;
		int               sent;
		int               run_len;
		logic             mark;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset weights are zero: every sample filters to zero
		send_sample(SMP_MAX, 1'b1);
		send_sample(SMP_MIN, 1'b0);
		send_sample('0, 1'b1);
		drain();

		// Unity input weight on the output lane: pass the sample through
		load_weights(pack_lanes(0, 0, COEF_ONE), '0, '0, 1'b1);
		send_sample(SMP_MAX, 1'b0);
		send_sample(SMP_MIN, 1'b1);
		send_sample(SAMPLE_WIDTH'(1), 1'b0);
		send_sample(SAMPLE_WIDTH'(-1), 1'b0);
		send_sample('0, 1'b1);
		send_sample(SAMPLE_WIDTH'(24'h400000), 1'b0);
		drain();

		// Half weight on odd samples: ties round toward plus infinity
		load_weights(pack_lanes(0, 0, COEF_ONE / 2), '0, '0, 1'b0);
		send_sample(SAMPLE_WIDTH'(1), 1'b0);
		send_sample(SAMPLE_WIDTH'(-1), 1'b0);
		send_sample(SAMPLE_WIDTH'(3), 1'b1);
		send_sample(SAMPLE_WIDTH'(-3), 1'b0);
		drain();

		// Largest weights everywhere: drive both states and the output to the top rail
		load_weights(pack_lanes(COEF_MAX, COEF_MAX, COEF_MAX),
			pack_lanes(COEF_MAX, COEF_MAX, COEF_MAX),
			pack_lanes(COEF_MAX, COEF_MAX, COEF_MAX), 1'b1);
		repeat (4) send_sample(SMP_MAX, 1'b0);
		send_sample(SMP_MIN, 1'b1);
		drain();

		// Most negative weights everywhere: swing to the bottom rail and back
		load_weights(pack_lanes(COEF_MIN, COEF_MIN, COEF_MIN),
			pack_lanes(COEF_MIN, COEF_MIN, COEF_MIN),
			pack_lanes(COEF_MIN, COEF_MIN, COEF_MIN), 1'b0);
		send_sample(SMP_MAX, 1'b0);
		send_sample(SMP_MAX, 1'b1);
		send_sample(SMP_MIN, 1'b0);
		send_sample(SMP_MIN, 1'b1);
		drain();

		// Random phases under three idling patterns
		for (int mode = 0; mode < 3; mode++) begin
			case (mode)
				0: begin
					send_idle_pct = 10;
					recv_idle_pct = 51;
				end
				1: begin
					send_idle_pct = 51;
					recv_idle_pct = 10;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			sent = 0;
			while (sent < ITEMS_PER_MODE) begin
				pick_weights(w_in, w_s1, w_s2);
				load_weights(w_in, w_s1, w_s2, $urandom_range(0, 3) == 0);
				run_len = $urandom_range(40, 120);
				repeat (run_len) begin
					if (block_left == 0) begin
						block_left = $urandom_range(1, 48);
					end
					mark = (block_left == 1);
					block_left--;
					send_sample(pick_sample(), mark);
				end
				sent += run_len;
				drain();
			end
		end

		if (mismatch_total == 0 && samples_in_flight == 0) begin
			$display("** trapezoidal_svf_core: PASSED **");
		end else begin
			$display("** trapezoidal_svf_core: FAILED **");
		end
		$finish;
	end

endmodule
